>>> sv/ami_pkg.sv
// ============================================================================
// ami_pkg: shared types and constants of the affine matrix inverse unit
// Defines the element width and the packed beats of the matrix and row
// channels.
// ============================================================================
package ami_pkg;

  localparam int ELEM_WIDTH = 32;
  localparam int FRAC_BITS_DEFAULT = 16;

  typedef logic signed [ELEM_WIDTH-1:0] elem_t;

  typedef struct packed {
    elem_t a11;
    elem_t a12;
    elem_t a13;
    elem_t a14;
    elem_t a21;
    elem_t a22;
    elem_t a23;
    elem_t a24;
    elem_t a31;
    elem_t a32;
    elem_t a33;
    elem_t a34;
  } mat_t;

  typedef struct packed {
    logic [1:0] row_index;
    elem_t      col1;
    elem_t      col2;
    elem_t      col3;
    elem_t      col4;
    logic       singular;
    logic       last_row;
  } inv_t;

endpackage

>>> sv/ami_div.sv
// ============================================================================
// ami_div: pipelined restoring divider
// Produces QW quotient bits of num / den, one bit per stage, and flags a
// quotient that does not fit in QW bits.
// ============================================================================
module ami_div #(
  parameter int QW = ami_pkg::ELEM_WIDTH,
  parameter int XW = 4 * ami_pkg::ELEM_WIDTH
) (
  input  logic          clk,
  input  logic          en,
  input  logic [XW-1:0] num,
  input  logic [XW-1:0] den,
  output logic [QW-1:0] q,
  output logic          ovf
);
  import ami_pkg::*;

  logic [XW-1:0] rem  [QW+1];
  logic [XW-1:0] dv   [QW+1];
  logic [QW-1:0] quo  [QW+1];
  logic          ov   [QW+1];

  // The first stage decides overflow; without it, every later remainder is below den << QW.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num;
      dv[0]  <= den;
      quo[0] <= '0;
      ov[0]  <= (num >= (den << QW));
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [XW-1:0] trial;
    logic          fits;
    always_comb begin
      trial = dv[k-1] << (QW - k);
      fits  = (rem[k-1] >= trial);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= fits ? (rem[k-1] - trial) : rem[k-1];
        dv[k]  <= dv[k-1];
        ov[k]  <= ov[k-1];
        quo[k] <= quo[k-1] | (fits ? (QW'(1) << (QW - k)) : '0);
      end
    end
  end

  assign q   = quo[QW];
  assign ovf = ov[QW];

endmodule

>>> sv/affine_matrix_inverse_unit.sv
// ============================================================================
// affine_matrix_inverse_unit: inverse of a 3x4 affine matrix in fixed point
// Takes one matrix beat and returns three row beats of the inverse.
// ============================================================================
// Row 0 of a matrix passes the holding register, stages 0 to 7, the dividers
// and the output register; rows 1 and 2 follow it. A matrix is taken when
// none is held or as row 2 issues, set by the single row output; the pipeline
// itself takes one row per cycle unless stalled; each divider step is a stage.
// Reset clears the valid bits of every stage and of the matrix holding register.
module affine_matrix_inverse_unit #(
  parameter int FRAC_BITS = ami_pkg::FRAC_BITS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         mat_valid,
  output logic         mat_stall,
  input  ami_pkg::mat_t mat,
  output logic         inv_valid,
  input  logic         inv_stall,
  output ami_pkg::inv_t inv
);
  import ami_pkg::*;

  localparam int W   = ELEM_WIDTH;
  localparam int CW  = 2 * W + 1;               // cofactor
  localparam int DPW = 3 * W + 1;               // cofactor times element
  localparam int DTW = 3 * W + 3;               // determinant, translation sum
  localparam int TAW = 3 * W + 4 + FRAC_BITS;   // translation numerator
  localparam int CAW = 2 * W + 1 + 2 * FRAC_BITS;
  localparam int AW  = (TAW > CAW) ? TAW : CAW;
  localparam int NPW = ((AW + 1 > DTW) ? AW + 1 : DTW) + 1;
  localparam int XW  = (NPW > DTW + 1 + W) ? NPW : DTW + 1 + W;
  localparam int DL  = W + 1;                   // divider latency

  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] ONE  = (FRAC_BITS < W - 1) ? (W'(1) << FRAC_BITS) : MAXV;

  typedef struct packed {
    logic [1:0] row;
    logic       last;
    logic       zero;
    logic [3:0] neg;
  } meta_t;

  // The whole pipeline moves as one: it advances whenever the output register
  // is empty or its beat is being taken, so a stall freezes every stage.
  logic en;
  assign en = !inv_valid || !inv_stall;

  // --------------------------------------------------------------------------
  // Matrix holding register and row sequencer. A matrix stays here while rows
  // 0, 1 and 2 are issued; the next matrix is taken in the same cycle that row 2
  // leaves.
  // --------------------------------------------------------------------------
  mat_t       hold;
  logic       hv;
  logic [1:0] rc;
  logic       accept;

  assign mat_stall = !(en && (!hv || rc == 2'd2));
  assign accept    = mat_valid && !mat_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hv <= 1'b0;
      rc <= 2'd0;
    end else if (en) begin
      if (accept) begin
        hv <= 1'b1;
        rc <= 2'd0;
      end else if (hv) begin
        if (rc == 2'd2) begin
          hv <= 1'b0;
          rc <= 2'd0;
        end else begin
          rc <= rc + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold <= mat;
    end
  end

  elem_t am [3][4];
  assign am[0][0] = hold.a11;
  assign am[0][1] = hold.a12;
  assign am[0][2] = hold.a13;
  assign am[0][3] = hold.a14;
  assign am[1][0] = hold.a21;
  assign am[1][1] = hold.a22;
  assign am[1][2] = hold.a23;
  assign am[1][3] = hold.a24;
  assign am[2][0] = hold.a31;
  assign am[2][1] = hold.a32;
  assign am[2][2] = hold.a33;
  assign am[2][3] = hold.a34;

  // Row i of the adjugate holds the cofactors of column i of A. Rotating the
  // columns of A left by i lets one cyclic formula serve all three rows, and
  // the rotated column 0 then gives the determinant by expansion along it.
  elem_t rot [3][3];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        case (rc)
          2'd0:    rot[r][c] = am[r][c];
          2'd1:    rot[r][c] = am[r][(c + 1) % 3];
          default: rot[r][c] = am[r][(c + 2) % 3];
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: one row issued.
  // --------------------------------------------------------------------------
  logic       s0_v;
  elem_t      s0_b [3][3];
  elem_t      s0_t [3];
  logic [1:0] s0_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (en) begin
      s0_v <= hv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_b   <= rot;
      for (int r = 0; r < 3; r++) begin
        s0_t[r] <= am[r][3];
      end
      s0_row <= rc;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: the six element products of the three cofactors of this row.
  // --------------------------------------------------------------------------
  logic                  s1_v;
  logic signed [2*W-1:0] s1_p0 [3];
  logic signed [2*W-1:0] s1_p1 [3];
  elem_t                 s1_k [3];
  elem_t                 s1_t [3];
  logic [1:0]            s1_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= s0_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        s1_p0[j] <= s0_b[(j + 1) % 3][1] * s0_b[(j + 2) % 3][2];
        s1_p1[j] <= s0_b[(j + 1) % 3][2] * s0_b[(j + 2) % 3][1];
        s1_k[j]  <= s0_b[j][0];
      end
      s1_t   <= s0_t;
      s1_row <= s0_row;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: cofactors.
  // --------------------------------------------------------------------------
  logic                 s2_v;
  logic signed [CW-1:0] s2_c [3];
  elem_t                s2_k [3];
  elem_t                s2_t [3];
  logic [1:0]           s2_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        s2_c[j] <= CW'(s1_p0[j]) - CW'(s1_p1[j]);
      end
      s2_k   <= s1_k;
      s2_t   <= s1_t;
      s2_row <= s1_row;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: a cofactor is wider than an element, so each cofactor is split for
  // its products into a low half (unsigned) and a high half (signed).
  // --------------------------------------------------------------------------
  logic signed [W:0]     c_lo [3];
  logic signed [W:0]     c_hi [3];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      c_lo[j] = signed'({1'b0, s2_c[j][W-1:0]});
      c_hi[j] = signed'(s2_c[j][CW-1:W]);
    end
  end

  logic                  s3_v;
  logic signed [2*W:0]   s3_dl [3];
  logic signed [2*W:0]   s3_dh [3];
  logic signed [2*W:0]   s3_tl [3];
  logic signed [2*W:0]   s3_th [3];
  logic signed [CW-1:0]  s3_c [3];
  logic [1:0]            s3_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        s3_dl[j] <= s2_k[j] * c_lo[j];
        s3_dh[j] <= s2_k[j] * c_hi[j];
        s3_tl[j] <= s2_t[j] * c_lo[j];
        s3_th[j] <= s2_t[j] * c_hi[j];
      end
      s3_c   <= s2_c;
      s3_row <= s2_row;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: partial products recombined.
  // --------------------------------------------------------------------------
  logic                  s4_v;
  logic signed [DPW-1:0] s4_dp [3];
  logic signed [DPW-1:0] s4_tp [3];
  logic signed [CW-1:0]  s4_c [3];
  logic [1:0]            s4_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (en) begin
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        s4_dp[j] <= (DPW'(s3_dh[j]) <<< W) + DPW'(s3_dl[j]);
        s4_tp[j] <= (DPW'(s3_th[j]) <<< W) + DPW'(s3_tl[j]);
      end
      s4_c   <= s3_c;
      s4_row <= s3_row;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: determinant and the dot product of this row with the translation.
  // --------------------------------------------------------------------------
  logic                  s5_v;
  logic signed [DTW-1:0] s5_det;
  logic signed [DTW-1:0] s5_acc;
  logic signed [CW-1:0]  s5_c [3];
  logic [1:0]            s5_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (en) begin
      s5_v <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_det <= DTW'(s4_dp[0]) + DTW'(s4_dp[1]) + DTW'(s4_dp[2]);
      s5_acc <= DTW'(s4_tp[0]) + DTW'(s4_tp[1]) + DTW'(s4_tp[2]);
      s5_c   <= s4_c;
      s5_row <= s4_row;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: scaled numerators, magnitudes and quotient signs. The three
  // linear elements carry two fraction scalings, the translation one.
  // --------------------------------------------------------------------------
  logic signed [AW-1:0] numer [4];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      numer[j] = AW'(s5_c[j]) <<< (2 * FRAC_BITS);
    end
    numer[3] = -(AW'(s5_acc) <<< FRAC_BITS);
  end

  logic            s6_v;
  logic [AW-1:0]   s6_an [4];
  logic [DTW-1:0]  s6_ad;
  meta_t           s6_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_v <= 1'b0;
    end else if (en) begin
      s6_v <= s5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        s6_an[j]    <= numer[j][AW-1] ? unsigned'(-numer[j]) : unsigned'(numer[j]);
        s6_m.neg[j] <= numer[j][AW-1] ^ s5_det[DTW-1];
      end
      s6_ad     <= s5_det[DTW-1] ? unsigned'(-s5_det) : unsigned'(s5_det);
      s6_m.zero <= (s5_det == '0);
      s6_m.row  <= s5_row;
      s6_m.last <= (s5_row == 2'd2);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: rounding to nearest with ties away from zero is a floor of
  // (2n + d) / (2d) on magnitudes.
  // --------------------------------------------------------------------------
  logic           s7_v;
  logic [XW-1:0]  s7_num [4];
  logic [XW-1:0]  s7_den;
  meta_t          s7_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_v <= 1'b0;
    end else if (en) begin
      s7_v <= s6_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        s7_num[j] <= (XW'(s6_an[j]) << 1) + XW'(s6_ad);
      end
      s7_den <= XW'(s6_ad) << 1;
      s7_m   <= s6_m;
    end
  end

  // --------------------------------------------------------------------------
  // Four dividers, one per output column, with the row's sign and flag bits
  // riding alongside in a line of the same depth.
  // --------------------------------------------------------------------------
  logic [W-1:0] dq   [4];
  logic         dovf [4];

  for (genvar j = 0; j < 4; j++) begin : g_div
    ami_div #(
      .QW(W),
      .XW(XW)
    ) u_div (
      .clk(clk),
      .en (en),
      .num(s7_num[j]),
      .den(s7_den),
      .q  (dq[j]),
      .ovf(dovf[j])
    );
  end

  logic  mv [DL];
  meta_t mm [DL];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DL; k++) begin
        mv[k] <= 1'b0;
      end
    end else if (en) begin
      mv[0] <= s7_v;
      for (int k = 1; k < DL; k++) begin
        mv[k] <= mv[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mm[0] <= s7_m;
      for (int k = 1; k < DL; k++) begin
        mm[k] <= mm[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sign, saturation and the singular case, then the output register.
  // A negative result may reach one step further than a positive one.
  // --------------------------------------------------------------------------
  meta_t        fm;
  logic [W-1:0] col [4];

  assign fm = mm[DL-1];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (fm.zero) begin
        col[j] = (j < 3 && fm.row == 2'(j)) ? ONE : '0;
      end else if (fm.neg[j]) begin
        col[j] = (dovf[j] || dq[j] > HALF) ? HALF : -dq[j];
      end else begin
        col[j] = (dovf[j] || dq[j] > MAXV) ? MAXV : dq[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_valid <= 1'b0;
    end else if (en) begin
      inv_valid <= mv[DL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inv.row_index <= fm.row;
      inv.col1      <= signed'(col[0]);
      inv.col2      <= signed'(col[1]);
      inv.col3      <= signed'(col[2]);
      inv.col4      <= signed'(col[3]);
      inv.singular  <= fm.zero;
      inv.last_row  <= fm.last;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_accept_starts_row0 : assert property (@(posedge clk) disable iff (rst)
    (mat_valid && !mat_stall) |=> (hv && rc == 2'd0))
    else $error("matrix beat taken without restarting the row sequence");

  a_singular_no_shift : assert property (@(posedge clk) disable iff (rst)
    (inv_valid && inv.singular) |-> (inv.col4 == '0))
    else $error("singular row carries a translation");

  a_last_is_row2 : assert property (@(posedge clk) disable iff (rst)
    (inv_valid && inv.last_row) |-> (inv.row_index == 2'd2))
    else $error("last row flag on a row other than the third");

  a_row_order : assert property (@(posedge clk) disable iff (rst)
    (inv_valid && !inv_stall && inv.row_index == 2'd0) |=>
      (!inv_valid || inv.row_index == 2'd1))
    else $error("row 1 does not follow row 0");

endmodule
